// File: rtl/mi_pkg.sv
// Package for the modular inverse block: width constant, controller states
// and the command/status structs between controller and datapath. No dependencies.
`default_nettype none
package mi_pkg;
   localparam int WIDTH = 64;
   localparam int CW = $clog2(WIDTH + 1);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_LOAD  = 8'b0000_0010,
      ST_RED   = 8'b0000_0100,
      ST_CHECK = 8'b0000_1000,
      ST_DIV   = 8'b0001_0000,
      ST_UPD   = 8'b0010_0000,
      ST_FIX   = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic load;      // capture operands
      logic div_start; // start a division of num by den
      logic div_step;  // one restoring-division bit
      logic red_end;   // take the reduced value as a
      logic upd;       // Euclid update (mul of q by ym runs serially, see dp)
      logic fix;       // final correction
   } cmd_type;

   typedef struct packed {
      logic mod_zero;
      logic mod_one;
      logic a_zero;
      logic a_gt1;
      logic m_zero;
      logic div_done;
      logic upd_done;
   } stat_type;
endpackage
`default_nettype wire

// File: rtl/modular_inverse.sv
// Top level of the modular inverse block: controller plus datapath.
// Depends on mi_pkg, mi_control, mi_datapath.
//
//  channel | ports                          | handshake
//  request | req_value, req_modulus         | start & !busy
//  result  | rsp_inverse, rsp_status        | rsp_valid, one cycle
//
// One item at a time. Each Euclid step runs a check, a bit-serial restoring division
// and a shift-add multiply that walks the quotient bits.
// Reset clears the controller; the receiver cannot stall.
`default_nettype none
module modular_inverse (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic [mi_pkg::WIDTH-1:0] req_value,
   input  wire logic [mi_pkg::WIDTH-1:0] req_modulus,
   output logic                          rsp_valid,
   output logic [mi_pkg::WIDTH-1:0]      rsp_inverse,
   output logic                          rsp_status
);
   mi_pkg::cmd_type  cmd;
   mi_pkg::stat_type stat;
   logic [mi_pkg::WIDTH-1:0] inv;
   logic done, fail;

   mi_control u_ctl (.clock, .reset, .start, .stat, .busy, .cmd, .done, .fail);
   mi_datapath u_dp (.clock, .reset, .req_value, .req_modulus, .cmd, .stat,
                     .inv_out(inv));

   // result beat
   assign rsp_valid   = done;
   assign rsp_status  = fail;
   assign rsp_inverse = (fail || stat.mod_one) ? '0 : inv;
endmodule
`default_nettype wire

// File: rtl/mi_datapath.sv
// Datapath for the modular inverse: operand registers, a bit-serial divider
// and a shift-add multiplier for the coefficient update. Depends on mi_pkg.
`default_nettype none
module mi_datapath (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic [mi_pkg::WIDTH-1:0] req_value,
   input  wire logic [mi_pkg::WIDTH-1:0] req_modulus,
   input  wire mi_pkg::cmd_type         cmd,
   output mi_pkg::stat_type             stat,
   output logic [mi_pkg::WIDTH-1:0]     inv_out
);
   localparam int W = mi_pkg::WIDTH;
   localparam int CW = mi_pkg::CW;

   logic [W-1:0] a_ff, a_in, m_ff, m_in, mod_ff, mod_in;
   logic [W-1:0] xm_ff, xm_in, ym_ff, ym_in;
   logic         xneg_ff, xneg_in;
   // divider: quotient/dividend shift register and partial remainder
   logic [W-1:0] dq_ff, dq_in, dr_ff, dr_in, dd_ff, dd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   // serial multiply-accumulate t = xm + q*ym
   logic [W-1:0] acc_ff, acc_in, mq_ff, mq_in, mb_ff, mb_in;
   logic         mbusy_ff, mbusy_in;
   logic [W:0]   trial;
   logic [W-1:0] rsh;

   always_comb begin
      rsh   = {dr_ff[W-2:0], dq_ff[W-1]};
      trial = {dr_ff[W-1], rsh} - {1'b0, dd_ff};
   end

   always_comb begin
      a_in = a_ff; m_in = m_ff; mod_in = mod_ff; xm_in = xm_ff; ym_in = ym_ff;
      xneg_in = xneg_ff; dq_in = dq_ff; dr_in = dr_ff; dd_in = dd_ff;
      cnt_in = cnt_ff; acc_in = acc_ff; mq_in = mq_ff; mb_in = mb_ff;
      mbusy_in = mbusy_ff;
      if (cmd.load) begin
         a_in = req_value; m_in = req_modulus; mod_in = req_modulus;
         xm_in = W'(1); ym_in = '0; xneg_in = 1'b0;
      end
      // divide a by m (reduction divides value by modulus the same way)
      if (cmd.div_start) begin
         dq_in = a_ff; dr_in = '0; dd_in = m_ff; cnt_in = CW'(W);
      end
      if (cmd.div_step) begin
         if (!trial[W]) begin
            dr_in = trial[W-1:0]; dq_in = {dq_ff[W-2:0], 1'b1};
         end else begin
            dr_in = rsh; dq_in = {dq_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
      end
      if (cmd.red_end) a_in = dr_ff;
      // update: start serial multiply, then commit
      if (cmd.upd) begin
         if (!mbusy_ff) begin
            acc_in = xm_ff; mq_in = dq_ff; mb_in = ym_ff; mbusy_in = 1'b1;
         end else if (mq_ff != '0) begin
            if (mq_ff[0]) acc_in = acc_ff + mb_ff;
            mq_in = mq_ff >> 1; mb_in = mb_ff << 1;
         end else begin
            a_in = m_ff; m_in = dr_ff; xm_in = ym_ff; ym_in = acc_ff;
            xneg_in = !xneg_ff; mbusy_in = 1'b0;
         end
      end
      if (cmd.fix) begin
         if (xneg_ff && xm_ff != '0) xm_in = mod_ff - xm_ff;
      end
      if (reset) mbusy_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in; m_ff <= m_in; mod_ff <= mod_in; xm_ff <= xm_in; ym_ff <= ym_in;
      xneg_ff <= xneg_in; dq_ff <= dq_in; dr_ff <= dr_in; dd_ff <= dd_in;
      cnt_ff <= cnt_in; acc_ff <= acc_in; mq_ff <= mq_in; mb_ff <= mb_in;
      mbusy_ff <= mbusy_in;
   end

   // status toward the controller
   always_comb begin
      stat.mod_zero = (mod_ff == '0);
      stat.mod_one  = (mod_ff == W'(1));
      stat.a_zero   = (a_ff == '0);
      stat.a_gt1    = (a_ff > W'(1));
      stat.m_zero   = (m_ff == '0);
      stat.div_done = (cnt_ff == '0);
      stat.upd_done = mbusy_ff && (mq_ff == '0);
   end
   assign inv_out = xm_ff;
endmodule
`default_nettype wire

// File: rtl/mi_control.sv
// Controller for the modular inverse: sequences reduction, Euclid steps and
// the final correction. Depends on mi_pkg.
`default_nettype none
module mi_control (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire mi_pkg::stat_type stat,
   output logic                  busy,
   output mi_pkg::cmd_type       cmd,
   output logic                  done,
   output logic                  fail
);
   mi_pkg::state_type state_ff, state_in;
   logic red_ff, red_in, fail_ff, fail_in;

   always_comb begin
      state_in = state_ff; red_in = red_ff; fail_in = fail_ff;
      cmd = '0;
      unique case (state_ff)
         mi_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1; state_in = mi_pkg::ST_LOAD;
            end
         end
         mi_pkg::ST_LOAD: begin
            fail_in = 1'b0;
            if (stat.mod_zero) begin
               fail_in = 1'b1; state_in = mi_pkg::ST_DONE;
            end else if (stat.mod_one) begin
               state_in = mi_pkg::ST_DONE;
            end else begin
               cmd.div_start = 1'b1; red_in = 1'b1; state_in = mi_pkg::ST_DIV;
            end
         end
         mi_pkg::ST_DIV: begin
            if (stat.div_done) begin
               if (red_ff) begin
                  cmd.red_end = 1'b1; state_in = mi_pkg::ST_RED;
               end else begin
                  state_in = mi_pkg::ST_UPD;
               end
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         mi_pkg::ST_RED: begin
            red_in = 1'b0;
            if (stat.a_zero) begin
               fail_in = 1'b1; state_in = mi_pkg::ST_DONE;
            end else begin
               state_in = mi_pkg::ST_CHECK;
            end
         end
         mi_pkg::ST_CHECK: begin
            if (!stat.a_gt1) begin
               state_in = mi_pkg::ST_FIX;
            end else if (stat.m_zero) begin
               fail_in = 1'b1; state_in = mi_pkg::ST_DONE;
            end else begin
               cmd.div_start = 1'b1; state_in = mi_pkg::ST_DIV;
            end
         end
         mi_pkg::ST_UPD: begin
            cmd.upd = 1'b1;
            if (stat.upd_done) state_in = mi_pkg::ST_CHECK;
         end
         mi_pkg::ST_FIX: begin
            cmd.fix = 1'b1; state_in = mi_pkg::ST_DONE;
         end
         mi_pkg::ST_DONE: state_in = mi_pkg::ST_IDLE;
         default: state_in = mi_pkg::ST_IDLE;
      endcase
      if (reset) begin
         state_in = mi_pkg::ST_IDLE; red_in = 1'b0; fail_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in; red_ff <= red_in; fail_ff <= fail_in;
   end

   assign busy = (state_ff != mi_pkg::ST_IDLE);
   assign done = (state_ff == mi_pkg::ST_DONE);
   assign fail = fail_ff;

   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done |=> state_ff == mi_pkg::ST_IDLE) else $error("done not followed by idle");
   a_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> state_ff == mi_pkg::ST_LOAD) else $error("start lost");
endmodule
`default_nettype wire

// File: verif/tb.sv
// Testbench for modular_inverse: directed and random operand pairs, each
// result checked against a built-in extended Euclid predictor. Depends on mi_pkg.
`default_nettype none
module tb;
   localparam int W = mi_pkg::WIDTH;
   localparam int LIMIT = 6_000_000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic [W-1:0]     req_value = '0;
   logic [W-1:0]     req_modulus = '0;
   logic             rsp_valid;
   logic [W-1:0]     rsp_inverse;
   logic             rsp_status;

   typedef struct packed {
      logic [W-1:0] inverse;
      logic         status;
   } inv_result_type;

   inv_result_type pending_inverses[$];
   int errors = 0;
   int cycles = 0;
   int gap_pct = 0;

   modular_inverse DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_value(req_value), .req_modulus(req_modulus),
      .rsp_valid(rsp_valid), .rsp_inverse(rsp_inverse), .rsp_status(rsp_status)
   );

   always #1 clock = ~clock;

   // Extended Euclid with magnitude plus alternating sign
   function automatic inv_result_type predict_inverse(logic [W-1:0] v,
                                                      logic [W-1:0] md);
      logic [W-1:0] a, m, xm, ym, q, r, t;
      logic neg;
      inv_result_type res;
      res = '{inverse: '0, status: 1'b1};
      if (md == 0) return res;
      if (md == 1) begin
         res.status = 1'b0;
         return res;
      end
      a = v % md;
      if (a == 0) return res;
      m = md; xm = W'(1); ym = '0; neg = 1'b0;
      while (a > 1) begin
         if (m == 0) return res;
         q = a / m; r = a % m;
         a = m; m = r;
         t = xm + q * ym;
         xm = ym; ym = t;
         neg = ~neg;
      end
      xm = xm % md;
      if (neg && xm != 0) xm = md - xm;
      res.inverse = xm;
      res.status = 1'b0;
      return res;
   endfunction

   // Cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Result checker
   always @(posedge clock) begin
      inv_result_type exp_r;
      if (!reset && rsp_valid) begin
         if (pending_inverses.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %h/%b", rsp_inverse, rsp_status);
         end else begin
            exp_r = pending_inverses.pop_front();
            if (rsp_inverse !== exp_r.inverse || rsp_status !== exp_r.status) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: expected %h/%b actual %h/%b",
                           exp_r.inverse, exp_r.status, rsp_inverse, rsp_status);
            end
         end
      end
   end

   // Send one beat, with random idle cycles before it; start stays high
   // until the next idle cycle or the drain
   task automatic send_pair(logic [W-1:0] v, logic [W-1:0] md);
      while ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_value <= v;
      req_modulus <= md;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_inverses.push_back(predict_inverse(v, md));
   endtask

   function automatic logic [W-1:0] rand_word();
      return {$urandom(), $urandom()};
   endfunction

   task automatic test_directed();
      send_pair(64'd0, 64'd7);
      send_pair(64'd5, 64'd1);
      send_pair('1, 64'd1);
      send_pair(64'd3, 64'd7);
      send_pair(64'd14, 64'd7);
      send_pair(64'd6, 64'd9);
      send_pair(64'd1, 64'd2);
      send_pair('1, '1);
      send_pair(64'hFFFF_FFFF_FFFF_FFFE, '1);
      send_pair('1, 64'hFFFF_FFFF_FFFF_FFC5);
      send_pair(64'h8000_0000_0000_0000, '1);
      send_pair(64'd2, 64'h8000_0000_0000_0000);
      send_pair(64'h0123_4567_89AB_CDEF, 64'hFFFF_FFFF_FFFF_FFC5);
      send_pair(64'd89, 64'd144);
      send_pair(64'd12345, 64'd0);
      send_pair(64'd1, 64'hFFFF_FFFF_FFFF_FFC5);
   endtask

   task automatic test_random(int n);
      logic [W-1:0] v, md;
      for (int i = 0; i < n; i++) begin
         v = rand_word();
         md = rand_word() >> $urandom_range(63);
         if (md == 0) md = W'(1);
         if ($urandom_range(9) == 0) v = v % md;
         if ($urandom_range(9) == 0) md = md & ~64'd1;
         send_pair(v, md);
      end
   endtask

   task automatic test_drain();
      start <= 1'b0;
      while (pending_inverses.size() != 0 || busy) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      gap_pct = 13;
      test_directed();
      test_random(28);
      gap_pct = 79;
      test_random(28);
      gap_pct = 0;
      test_random(28);
      test_drain();
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
`default_nettype wire
